// File: design/gpd_pkg.sv
// Shared types, constants and helpers for the Gaussian pyramid down-sampler.
// No dependencies; every other design file uses these by scoped name.
package gpd_pkg;

    localparam int SIZE_BITS       = 11;    // frame_width / frame_height registers
    localparam int ROW_BITS        = 11;    // extended raster row counter
    localparam int PIXEL_PORT_BITS = 16;    // pixel field on the input stream
    localparam int VALUE_BITS      = 24;    // value field on the output stream
    localparam int CFG_INDEX_BITS  = 2;
    localparam int HEIGHT_LIMIT    = 1024;
    localparam int SIZE_RESET      = 640;
    localparam int SIZE_MAX        = (1 << SIZE_BITS) - 1;
    localparam int LINE_ROWS       = 4;     // rows held in the line store
    localparam int QUEUE_DEPTH     = 4;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_PIXEL_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Per-item control decided by the front end.
    typedef struct packed {
        logic [2:0] rows_above;  // valid rows above this one in the store, 0..4
        logic       col_zero;    // first column of an extended row
        logic       emit;        // window centre is an even row and column
        logic       last;        // final result of the output frame
    } t_ctrl;

    localparam int CTRL_BITS = 6;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Zero reads as one, anything above the limit saturates.
    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                        input logic [SIZE_BITS-1:0] hi);
        logic [SIZE_BITS-1:0] res;
        if (v == '0) begin
            res = SIZE_BITS'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: design/gpd_front.sv
// Front end: configuration registers, extended raster position and item classification.
// Depends on gpd_pkg.
module gpd_front #(
    parameter int MAX_WIDTH   = gpd_pkg::DEF_MAX_WIDTH,
    parameter int COL_BITS    = $clog2(gpd_pkg::DEF_MAX_WIDTH + 2),
    parameter int SAMPLE_BITS = gpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [gpd_pkg::SIZE_BITS-1:0]        i_cfg_data,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_kind,
    input  logic [gpd_pkg::PIXEL_PORT_BITS-1:0]  i_pixel,
    input  gpd_pkg::t_qstat                      i_qstat,
    output logic                                 o_s_tready,
    output logic                                 o_push,
    output gpd_pkg::t_ctrl                       o_ctrl,
    output logic [COL_BITS-1:0]                  o_col,
    output logic [SAMPLE_BITS-1:0]               o_sample,
    output logic                                 o_at_origin
);

    localparam int WIDTH_HI_INT = (MAX_WIDTH < gpd_pkg::SIZE_MAX) ? MAX_WIDTH : gpd_pkg::SIZE_MAX;
    localparam int WIDTH_RST_INT = (gpd_pkg::SIZE_RESET < WIDTH_HI_INT) ?
                                   gpd_pkg::SIZE_RESET : WIDTH_HI_INT;
    localparam logic [gpd_pkg::SIZE_BITS-1:0] WIDTH_HI  = gpd_pkg::SIZE_BITS'(WIDTH_HI_INT);
    localparam logic [gpd_pkg::SIZE_BITS-1:0] WIDTH_RST = gpd_pkg::SIZE_BITS'(WIDTH_RST_INT);
    localparam logic [gpd_pkg::SIZE_BITS-1:0] HEIGHT_HI =
        gpd_pkg::SIZE_BITS'(gpd_pkg::HEIGHT_LIMIT);
    localparam logic [gpd_pkg::SIZE_BITS-1:0] HEIGHT_RST =
        gpd_pkg::SIZE_BITS'(gpd_pkg::SIZE_RESET);

    logic [gpd_pkg::SIZE_BITS-1:0] r_frame_width,  n_frame_width;
    logic [gpd_pkg::SIZE_BITS-1:0] r_frame_height, n_frame_height;
    logic [COL_BITS-1:0]           r_col,  n_col;
    logic [gpd_pkg::ROW_BITS-1:0]  r_row,  n_row;

    logic [COL_BITS-1:0]           w_width_col;
    logic [COL_BITS-1:0]           w_width_m1;
    logic [COL_BITS-1:0]           w_end_col;
    logic [COL_BITS-1:0]           w_last_col;
    logic [gpd_pkg::SIZE_BITS-1:0] w_height_m1;
    logic [gpd_pkg::ROW_BITS-1:0]  w_last_row;
    logic                          w_inside;
    logic                          w_cfg_hit;

    assign w_width_col = COL_BITS'(r_frame_width);
    assign w_width_m1  = w_width_col - COL_BITS'(1);
    assign w_end_col   = w_width_col + COL_BITS'(1);
    assign w_last_col  = {w_width_m1[COL_BITS-1:1], 1'b0} + COL_BITS'(2);
    assign w_height_m1 = r_frame_height - gpd_pkg::SIZE_BITS'(1);
    assign w_last_row  = gpd_pkg::ROW_BITS'({w_height_m1[gpd_pkg::SIZE_BITS-1:1], 1'b0})
                         + gpd_pkg::ROW_BITS'(2);

    assign w_inside = (r_row < gpd_pkg::ROW_BITS'(r_frame_height)) && (r_col < w_width_col);

    assign o_s_tready  = !i_qstat.full;
    assign o_push      = i_s_tvalid && !i_qstat.full;
    assign o_col       = r_col;
    assign o_sample    = (i_kind == gpd_pkg::KIND_PIXEL && w_inside) ?
                         i_pixel[SAMPLE_BITS-1:0] : '0;
    assign o_at_origin = (r_col == '0) && (r_row == '0);

    always_comb begin
        o_ctrl.rows_above = (r_row >= gpd_pkg::ROW_BITS'(gpd_pkg::LINE_ROWS)) ?
                            3'(gpd_pkg::LINE_ROWS) : r_row[2:0];
        o_ctrl.col_zero   = (r_col == '0);
        o_ctrl.emit       = (r_row >= gpd_pkg::ROW_BITS'(2)) && (r_col >= COL_BITS'(2))
                            && !r_row[0] && !r_col[0];
        o_ctrl.last       = (r_row == w_last_row) && (r_col == w_last_col);
    end

    assign w_cfg_hit = i_cfg_valid && (i_cfg_index == gpd_pkg::CFG_FRAME_WIDTH ||
                                       i_cfg_index == gpd_pkg::CFG_FRAME_HEIGHT);

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_col          = r_col;
        n_row          = r_row;
        if (w_cfg_hit) begin
            // a register write restarts the extended raster
            if (i_cfg_index == gpd_pkg::CFG_FRAME_WIDTH) begin
                n_frame_width = gpd_pkg::clamp_size(i_cfg_data, WIDTH_HI);
            end else begin
                n_frame_height = gpd_pkg::clamp_size(i_cfg_data, HEIGHT_HI);
            end
            n_col = '0;
            n_row = '0;
        end else if (o_push) begin
            if (r_col == w_end_col) begin
                n_col = '0;
                if (r_row == gpd_pkg::ROW_BITS'(r_frame_height) + gpd_pkg::ROW_BITS'(1)) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + gpd_pkg::ROW_BITS'(1);
                end
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_col          <= n_col;
            r_row          <= n_row;
        end
    end

endmodule

// File: design/gpd_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Depends on gpd_pkg for the status struct.
module gpd_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = gpd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output gpd_pkg::t_qstat  o_stat
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    assign o_data       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        n_count = r_count + CNT_BITS'(i_push) - CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/gpd_back.sv
// Back end: line store memory, vertical and horizontal binomial sums, output register.
// Depends on gpd_pkg.
module gpd_back #(
    parameter int MAX_WIDTH   = gpd_pkg::DEF_MAX_WIDTH,
    parameter int COL_BITS    = $clog2(gpd_pkg::DEF_MAX_WIDTH + 2),
    parameter int SAMPLE_BITS = gpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gpd_pkg::t_qstat                 i_qstat,
    input  gpd_pkg::t_ctrl                  i_ctrl,
    input  logic [COL_BITS-1:0]             i_col,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_pop,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [gpd_pkg::VALUE_BITS-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int DEPTH   = MAX_WIDTH + 2;
    localparam int S       = SAMPLE_BITS;
    localparam int VS_BITS = SAMPLE_BITS + 4;
    localparam int HS_BITS = SAMPLE_BITS + 8;
    localparam int ROWS    = gpd_pkg::LINE_ROWS;

    // slot 0 holds the row just above, slot 3 the row four above
    logic [ROWS*S-1:0]    r_line_mem [DEPTH];
    logic [ROWS*S-1:0]    r_rd;

    logic                 w_en;
    logic                 r_a_valid;
    gpd_pkg::t_ctrl       r_a_ctrl;
    logic [COL_BITS-1:0]  r_a_col;
    logic [S-1:0]         r_a_sample;

    logic                 r_b_valid;
    gpd_pkg::t_ctrl       r_b_ctrl;
    logic [VS_BITS-1:0]   r_b_vsum;

    logic [VS_BITS-1:0]   r_hw [4];
    logic [VS_BITS-1:0]   w_prev [4];

    logic [S-1:0]         w_c0, w_c1, w_c2, w_c3;
    logic [ROWS*S-1:0]    w_word;
    logic [VS_BITS-1:0]   w_vsum;
    logic [HS_BITS-1:0]   w_hsum;

    logic                 r_out_valid;
    logic [HS_BITS-1:0]   r_out_value;
    logic                 r_out_last;

    // advance the whole pipe whenever the output register is free or being taken
    assign w_en  = !r_out_valid || i_m_tready;
    assign o_pop = w_en && !i_qstat.empty;

    // stale rows from an earlier frame read as zero
    assign w_c3 = (r_a_ctrl.rows_above >= 3'd1) ? r_rd[0*S +: S] : '0;
    assign w_c2 = (r_a_ctrl.rows_above >= 3'd2) ? r_rd[1*S +: S] : '0;
    assign w_c1 = (r_a_ctrl.rows_above >= 3'd3) ? r_rd[2*S +: S] : '0;
    assign w_c0 = (r_a_ctrl.rows_above >= 3'd4) ? r_rd[3*S +: S] : '0;

    assign w_word = {w_c1, w_c2, w_c3, r_a_sample};

    assign w_vsum = VS_BITS'(w_c0) + (VS_BITS'(w_c1) << 2) + (VS_BITS'(w_c2) << 2)
                  + (VS_BITS'(w_c2) << 1) + (VS_BITS'(w_c3) << 2) + VS_BITS'(r_a_sample);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_prev[k] = r_b_ctrl.col_zero ? '0 : r_hw[k];
        end
    end

    assign w_hsum = HS_BITS'(w_prev[0]) + (HS_BITS'(w_prev[1]) << 2)
                  + (HS_BITS'(w_prev[2]) << 2) + (HS_BITS'(w_prev[2]) << 1)
                  + (HS_BITS'(w_prev[3]) << 2) + HS_BITS'(r_b_vsum);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd <= r_line_mem[i_col];
        end
        if (w_en && r_a_valid) begin
            r_line_mem[r_a_col] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= o_pop;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid && r_b_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ctrl   <= i_ctrl;
            r_a_col    <= i_col;
            r_a_sample <= i_sample;
            r_b_ctrl   <= r_a_ctrl;
            r_b_vsum   <= w_vsum;
            if (r_b_valid) begin
                r_hw[0] <= w_prev[1];
                r_hw[1] <= w_prev[2];
                r_hw[2] <= w_prev[3];
                r_hw[3] <= r_b_vsum;
            end
            if (r_b_valid && r_b_ctrl.emit) begin
                r_out_value <= w_hsum;
                r_out_last  <= r_b_ctrl.last;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = gpd_pkg::VALUE_BITS'(r_out_value);
    assign o_m_tlast  = r_out_last;

endmodule

// File: design/gaussian_pyramid_downsample.sv
// Top level of the 5x5 Gaussian pyramid down-sampler: front end, queue and back end.
// Depends on gpd_pkg, gpd_front, gpd_queue and gpd_back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------
//  s stream | in        | i_s_tvalid / o_s_tready   | tdata: pixel[15:0]; tuser: kind
//  m stream | out       | o_m_tvalid / i_m_tready   | tdata: value[23:0]; tlast: last
//  config   | in        | i_cfg_valid / o_cfg_ready | index[1:0], data[10:0]
//
// One input request is taken every clock unless the queue is full; the line store
// is a single-port-per-side memory read and written once per item, which sets that
// rate. An item passes through the queue and stages A and B to the output register.
// Reset is synchronous, active low, and needs no clearing pass: rows above the current
// one that belong to an earlier frame are masked by the row count. An output stall
// holds the whole back pipe and the queue absorbs up to four items before ready drops.
module gaussian_pyramid_downsample #(
    parameter int MAX_WIDTH  = gpd_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gpd_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [gpd_pkg::PIXEL_PORT_BITS-1:0] i_s_tdata,   // [15:0] pixel
    input  logic                                i_s_tuser,   // [0] kind
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gpd_pkg::VALUE_BITS-1:0]      o_m_tdata,   // [23:0] value
    output logic                                o_m_tlast,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [gpd_pkg::SIZE_BITS-1:0]       i_cfg_data
);

    // samples never exceed the pixel port width
    localparam int SAMPLE_BITS = (PIXEL_BITS < gpd_pkg::PIXEL_PORT_BITS) ?
                                 PIXEL_BITS : gpd_pkg::PIXEL_PORT_BITS;
    localparam int COL_BITS    = $clog2(MAX_WIDTH + 2);
    localparam int Q_WIDTH     = gpd_pkg::CTRL_BITS + COL_BITS + SAMPLE_BITS;

    gpd_pkg::t_qstat        w_qstat;
    gpd_pkg::t_ctrl         w_f_ctrl;
    gpd_pkg::t_ctrl         w_b_ctrl;
    logic [COL_BITS-1:0]    w_f_col,    w_b_col;
    logic [SAMPLE_BITS-1:0] w_f_sample, w_b_sample;
    logic [Q_WIDTH-1:0]     w_q_in,     w_q_out;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_at_origin;

    // registers are always writable; write only while idle; the block does not check
    assign o_cfg_ready = 1'b1;

    gpd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .COL_BITS    (COL_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_kind      (i_s_tuser),
        .i_pixel     (i_s_tdata),
        .i_qstat     (w_qstat),
        .o_s_tready  (o_s_tready),
        .o_push      (w_push),
        .o_ctrl      (w_f_ctrl),
        .o_col       (w_f_col),
        .o_sample    (w_f_sample),
        .o_at_origin (w_at_origin)
    );

    // pack classified item for the queue
    assign w_q_in = {w_f_ctrl, w_f_col, w_f_sample};
    assign {w_b_ctrl, w_b_col, w_b_sample} = w_q_out;

    gpd_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (gpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_qstat)
    );

    gpd_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .COL_BITS    (COL_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (w_qstat),
        .i_ctrl     (w_b_ctrl),
        .i_col      (w_b_col),
        .i_sample   (w_b_sample),
        .o_pop      (w_pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // hold the back pipe while a result waits: nothing may leave the queue
    a_no_pop_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_pop)
        else $error("queue popped while the output request was stalled");

    // a register write restarts the raster at its origin
    a_cfg_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == gpd_pkg::CFG_FRAME_WIDTH ||
                                        i_cfg_index == gpd_pkg::CFG_FRAME_HEIGHT))
        |=> w_at_origin)
        else $error("raster position not restarted after a register write");

    // the queue fills only through a push
    a_full_by_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_qstat.full) |-> $past(w_push))
        else $error("queue became full without a push");

endmodule
